// ===== hdl/ihex_pkg.sv =====
// Shared types, result codes and hex digit decoding for the HEX record loader.
`timescale 1ns / 1ps

package ihex_pkg;

  // Input item: one file character or the end-of-input mark
  typedef struct packed {
    logic       action;
    logic [7:0] character;
  } char_item_t;

  // Result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
  } rec_item_t;

  // Result kinds
  localparam logic [2:0] KIND_WRITE  = 3'd0;
  localparam logic [2:0] KIND_BADSUM = 3'd1;
  localparam logic [2:0] KIND_DONE   = 3'd2;
  localparam logic [2:0] KIND_START  = 3'd3;
  localparam logic [2:0] KIND_FORMAT = 3'd4;

  // Input actions
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Record types
  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EOF  = 8'h01;

  // Characters of note
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CASE_BIT     = 8'h20;

  // Hex digit decode: bit 4 set flags a character that is no hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] l;
    l = c | CASE_BIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_value = {1'b0, 4'(c - 8'h30)};
    end else if (l >= 8'h61 && l <= 8'h66) begin
      hex_value = {1'b0, 4'(l - 8'h57)};
    end else begin
      hex_value = 5'h10;
    end
  endfunction

endpackage

// ===== hdl/intel_hex_record_loader_core.sv =====
// Intel HEX record loader: character parser with registered, skid-buffered result port.
`timescale 1ns / 1ps

// Usage
//   char_*    : input items, one file character (action 0) or end of input (action 1).
//               An item is taken at a clock edge with char_valid high and char_stall low.
//   rec_*     : result items (memory write, checksum mismatch, done, done with start,
//               format error). Taken at an edge with rec_valid high and rec_stall low.
//   autorun_* : write port for the autorun bit; always ready, write only while idle.
// Throughput: one character per cycle while char_stall is low. Each character updates
//   the parse fields combinationally; the result register holds what it produces.
// A result is registered on rec_item, or in the skid entry while the output is held.
// Stall: a one-entry skid register catches a result while rec_stall holds the output
//   register; char_stall rises only while that skid entry is occupied, so at most
//   one extra character is absorbed and nothing is lost or repeated.
// Reset (rst, synchronous): parser waits for a record start, autorun is clear, and
//   both result registers are empty. After a load finishes, characters are ignored
//   until an end-of-input item rearms the parser.
module intel_hex_record_loader_core
  import ihex_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_item_t char_item,
  output logic       rec_valid,
  input  logic       rec_stall,
  output rec_item_t  rec_item,
  input  logic       autorun_valid,
  output logic       autorun_ready,
  input  logic       autorun_data
);

  // Parse phases
  localparam logic [3:0] PH_START = 4'd0;
  localparam logic [3:0] PH_LEN_H = 4'd1;
  localparam logic [3:0] PH_LEN_L = 4'd2;
  localparam logic [3:0] PH_AHI_H = 4'd3;
  localparam logic [3:0] PH_AHI_L = 4'd4;
  localparam logic [3:0] PH_ALO_H = 4'd5;
  localparam logic [3:0] PH_ALO_L = 4'd6;
  localparam logic [3:0] PH_TYP_H = 4'd7;
  localparam logic [3:0] PH_TYP_L = 4'd8;
  localparam logic [3:0] PH_DAT_H = 4'd9;
  localparam logic [3:0] PH_DAT_L = 4'd10;
  localparam logic [3:0] PH_SUM_H = 4'd11;
  localparam logic [3:0] PH_SUM_L = 4'd12;
  localparam logic [3:0] PH_EOL   = 4'd13;

  // Parser state
  logic [3:0]  phase, phase_next;
  logic [3:0]  high_digit, high_digit_next;
  logic [7:0]  record_length, record_length_next;
  logic [15:0] load_address, load_address_next;
  logic [7:0]  record_type, record_type_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  running_sum, running_sum_next;
  logic        stopped, stopped_next;
  logic        autorun;

  // Output register and skid entry
  logic        out_valid;
  rec_item_t   out_item;
  logic        skid_valid;
  rec_item_t   skid_item;

  logic        char_fire;
  logic        out_free;
  logic        res_valid;
  rec_item_t   res;
  logic [4:0]  nib;
  logic [7:0]  byte_val;
  logic [7:0]  left_dec;

  assign char_fire     = char_valid & ~char_stall;
  assign char_stall    = skid_valid;
  assign rec_valid     = out_valid;
  assign rec_item      = out_item;
  assign autorun_ready = 1'b1;
  assign out_free      = ~out_valid | ~rec_stall;

  // Byte assembly from the current low digit
  assign nib      = hex_value(char_item.character);
  assign byte_val = nib[4] ? 8'hFF : {high_digit, nib[3:0]};
  assign left_dec = bytes_left - 8'd1;

  // Per-character parse step
  always_comb begin
    phase_next         = phase;
    high_digit_next    = high_digit;
    record_length_next = record_length;
    load_address_next  = load_address;
    record_type_next   = record_type;
    bytes_left_next    = bytes_left;
    running_sum_next   = running_sum;
    stopped_next       = stopped;
    res_valid          = 1'b0;
    res                = '{kind: KIND_DONE, address: 16'h0000, data: 8'h00};

    if (char_fire) begin
      if (char_item.action == ACT_END) begin
        // rearm; report done only if the load was still running
        phase_next         = PH_START;
        high_digit_next    = 4'h0;
        record_length_next = 8'h00;
        load_address_next  = 16'h0000;
        record_type_next   = 8'h00;
        bytes_left_next    = 8'h00;
        running_sum_next   = 8'h00;
        stopped_next       = 1'b0;
        res_valid          = ~stopped;
      end else if (!stopped) begin
        if (phase == PH_START) begin
          if (char_item.character != CHAR_COLON) begin
            stopped_next = 1'b1;
            res_valid    = 1'b1;
            res.kind     = KIND_FORMAT;
          end else begin
            running_sum_next  = 8'h00;
            load_address_next = 16'h0000;
            phase_next        = PH_LEN_H;
          end
        end else if (phase == PH_EOL) begin
          if (char_item.character == CHAR_NEWLINE) begin
            if (record_type == TYPE_EOF) begin
              stopped_next = 1'b1;
              res_valid    = 1'b1;
              if (autorun && load_address != 16'h0000) begin
                res.kind    = KIND_START;
                res.address = load_address;
              end
            end else begin
              phase_next = PH_START;
            end
          end
        end else if (phase > PH_SUM_L) begin
          phase_next = PH_START;
        end else if (phase[0]) begin
          // high digit of a pair
          high_digit_next = nib[4] ? 4'hF : nib[3:0];
          phase_next      = phase + 4'd1;
        end else begin
          // low digit completes a byte
          running_sum_next = running_sum + byte_val;
          case (phase)
            PH_LEN_L: begin
              record_length_next = byte_val;
              phase_next         = PH_AHI_H;
            end
            PH_AHI_L, PH_ALO_L: begin
              load_address_next = {load_address[7:0], byte_val};
              phase_next        = phase + 4'd1;
            end
            PH_TYP_L: begin
              record_type_next = byte_val;
              bytes_left_next  = record_length;
              phase_next       = (record_length != 8'h00) ? PH_DAT_H : PH_SUM_H;
            end
            PH_DAT_L: begin
              if (record_type == TYPE_DATA) begin
                res_valid         = 1'b1;
                res.kind          = KIND_WRITE;
                res.address       = load_address;
                res.data          = byte_val;
                load_address_next = load_address + 16'd1;
              end
              bytes_left_next = left_dec;
              phase_next      = (left_dec != 8'h00) ? PH_DAT_H : PH_SUM_H;
            end
            default: begin
              // checksum byte: sum of all record bytes must wrap to zero
              running_sum_next = running_sum;
              phase_next       = PH_EOL;
              if (8'(running_sum + byte_val) != 8'h00) begin
                res_valid = 1'b1;
                res.kind  = KIND_BADSUM;
              end
            end
          endcase
        end
      end
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      high_digit    <= 4'h0;
      record_length <= 8'h00;
      load_address  <= 16'h0000;
      record_type   <= 8'h00;
      bytes_left    <= 8'h00;
      running_sum   <= 8'h00;
      stopped       <= 1'b0;
    end else begin
      phase         <= phase_next;
      high_digit    <= high_digit_next;
      record_length <= record_length_next;
      load_address  <= load_address_next;
      record_type   <= record_type_next;
      bytes_left    <= bytes_left_next;
      running_sum   <= running_sum_next;
      stopped       <= stopped_next;
    end
  end

  // Autorun register
  always_ff @(posedge clk) begin
    if (rst) begin
      autorun <= 1'b0;
    end else if (autorun_valid && autorun_ready) begin
      autorun <= autorun_data;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Output payloads
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_item <= skid_valid ? skid_item : res;
    end
    if (!out_free && res_valid) begin
      skid_item <= res;
    end
  end

  // Skid entry only exists behind a full output register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry occupied while output register empty");

  // Skid entry only fills while the output register is held
  assert property (@(posedge clk) disable iff (rst)
      $rose(skid_valid) |-> $past(out_valid && rec_stall))
    else $error("skid entry filled without a held output");

  // A stopped parser ignores characters
  assert property (@(posedge clk) disable iff (rst)
      (char_fire && stopped && char_item.action == ACT_CHAR) |-> !res_valid)
    else $error("result produced after load stopped");

  // Memory writes only come from data bytes
  assert property (@(posedge clk) disable iff (rst)
      (res_valid && res.kind == KIND_WRITE) |-> (phase == PH_DAT_L && record_type == TYPE_DATA))
    else $error("memory write outside a data byte");

  // A write advances the load address by one
  assert property (@(posedge clk) disable iff (rst)
      (res_valid && res.kind == KIND_WRITE) |=> load_address == 16'($past(load_address) + 16'd1))
    else $error("load address did not advance after a write");

endmodule
